FILE: design/bpgf_pkg.sv
// Shared types and constants of the binary pulse gap filter.
package bpgf_pkg;

	// Width of the signed distance arithmetic on sample indices.
	localparam int DW = 36;
	typedef logic signed [DW-1:0] wide_t;

	localparam logic [15:0] RUN_MAX   = 16'hFFFF;
	localparam int          MERGE_MAX = 63;

	// Configuration register indexes.
	localparam logic REG_MIN_RUN = 1'b0;
	localparam logic REG_MAX_GAP = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic look;
		logic decide;
		logic push;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic chan_ok;
		logic rem_nz;
		logic rem_last;
		logic out_free;
	} sts_t;

endpackage

FILE: design/binary_pulse_gap_filter_core.sv
// Top level of the binary pulse gap filter: controller plus datapath.
// The controller takes each accepted item through a look state and a decide state before its burst phase.
// An item holds the block (in_stall high) until its burst is sent; a burst is 1 to 64 bits,
// one bit per cycle through the single output register, or empty when the item emits nothing.
// Output stalls stretch the burst phase cycle for cycle.
// Reset (arst_n low) clears all channel state and restores min run 10 and max gap 40.
module binary_pulse_gap_filter_core
	import bpgf_pkg::*;
#(
	parameter int CHANNELS  = 3,
	parameter int MAX_BURST = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  channel,
	input  logic        sample_bit,
	input  logic        previous_bit,
	input  logic [31:0] sample_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_channel,
	output logic        filtered_bit,
	output logic        last_of_burst
);

	// The controller sequences each item through a distance stage, a decision
	// stage and the bit-per-cycle burst phase; the datapath holds all channel and burst state.
	cmd_t cmd;
	sts_t sts;

	bpgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpgf_datapath #(
		.CHANNELS  (CHANNELS),
		.MAX_BURST (MAX_BURST)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.channel       (channel),
		.sample_bit    (sample_bit),
		.previous_bit  (previous_bit),
		.sample_index  (sample_index),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_channel   (out_channel),
		.filtered_bit  (filtered_bit),
		.last_of_burst (last_of_burst)
	);

endmodule

FILE: design/bpgf_ctrl.sv
// Controller state machine of the binary pulse gap filter.
module bpgf_ctrl
	import bpgf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	assign in_stall = in_stall_q;

	always_comb begin
		cmd.latch  = (state_q == ST_IDLE) && in_valid && !in_stall_q;
		cmd.look   = (state_q == ST_LOOK);
		cmd.decide = (state_q == ST_DECIDE);
		cmd.push   = (state_q == ST_EMIT) && sts.rem_nz && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.latch) begin
						state_q    <= ST_LOOK;
						in_stall_q <= 1'b1;
					end
				end
				ST_LOOK: begin
					// Items of a channel that does not exist are dropped here.
					if (sts.chan_ok) begin
						state_q <= ST_DECIDE;
					end else begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!sts.rem_nz || (cmd.push && sts.rem_last)) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: design/bpgf_datapath.sv
// Datapath of the binary pulse gap filter: channel state, decisions and burst output.
module bpgf_datapath
	import bpgf_pkg::*;
#(
	parameter int CHANNELS  = 3,
	parameter int MAX_BURST = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic [1:0]  channel,
	input  logic        sample_bit,
	input  logic        previous_bit,
	input  logic [31:0] sample_index,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [1:0]  out_channel,
	output logic        filtered_bit,
	output logic        last_of_burst
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam logic [BW-1:0] BMAX = BW'(MAX_BURST);

	// Configuration.
	logic [3:0] min_q;
	logic [5:0] max_q;

	// Per-channel state.
	logic signed [32:0] lre_q [CHANNELS];
	logic [15:0]        rl_q  [CHANNELS];
	logic [3:0]         pwl_q [CHANNELS];
	logic               sp_q  [CHANNELS];
	logic               ril_q [CHANNELS];
	logic               gil_q [CHANNELS];
	logic [5:0]         mrg_q [CHANNELS];

	// Latched item.
	logic [1:0]  ch_q;
	logic        cur_q;
	logic        prev_q;
	logic [31:0] wi_q;
	logic [CW-1:0] idx;

	// Distances registered in the look state, the cycle before the decision.
	wide_t d_s1;
	wide_t dsum_s1;
	wide_t dwl_s1;

	// Burst counters.
	logic [BW-1:0] rem_q;
	logic [BW-1:0] ones_q;

	logic out_valid_q;
	logic [1:0] out_ch_q;
	logic out_bit_q;
	logic out_last_q;

	// Decision results.
	logic signed [32:0] n_lre;
	logic [15:0]        n_rl;
	logic [3:0]         n_pwl;
	logic               n_sp;
	logic               n_ril;
	logic               n_gil;
	logic [5:0]         n_mrg;
	logic [BW-1:0]      rem_n;
	logic [BW-1:0]      ones_n;

	function automatic logic [BW-1:0] clamp_burst(input wide_t v);
		if (v < 0) begin
			return '0;
		end else if (v > wide_t'(MAX_BURST)) begin
			return BMAX;
		end else begin
			return v[BW-1:0];
		end
	endfunction

	function automatic logic [5:0] clamp_merge(input wide_t v);
		if (v < 0) begin
			return '0;
		end else if (v > wide_t'(MERGE_MAX)) begin
			return 6'(MERGE_MAX);
		end else begin
			return v[5:0];
		end
	endfunction

	assign idx = CW'(ch_q);

	always_comb begin
		sts.chan_ok  = {2'b00, ch_q} < 4'(CHANNELS);
		sts.rem_nz   = (rem_q != '0);
		sts.rem_last = (rem_q == BW'(1));
		sts.out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		wide_t         sl;
		wide_t         dl;
		wide_t         wl;
		wide_t         mw;
		wide_t         d2;
		wide_t         zsum;
		logic [15:0]   rl_cur;
		logic          no_run;
		logic [BW-1:0] ones_a;
		logic [BW-1:0] ones_b;
		logic [BW-1:0] zeros;
		logic [BW:0]   ones_t;
		logic [BW-1:0] ones_e;
		logic [BW-1:0] room;
		logic [BW-1:0] zeros_e;

		sl     = wide_t'(min_q);
		dl     = wide_t'(max_q);
		rl_cur = rl_q[idx];
		no_run = (lre_q[idx] == -33'sd1);
		mw     = wide_t'(mrg_q[idx]);
		ones_a = '0;
		ones_b = '0;
		zeros  = '0;
		wl     = '0;
		d2     = '0;
		zsum   = '0;

		n_lre = lre_q[idx];
		n_rl  = rl_cur;
		n_pwl = pwl_q[idx];
		n_sp  = sp_q[idx];
		n_ril = ril_q[idx];
		n_gil = gil_q[idx];
		n_mrg = mrg_q[idx];

		if (cur_q) begin
			n_rl = (rl_cur != RUN_MAX) ? rl_cur + 16'd1 : rl_cur;
			wl   = wide_t'(n_rl);
			if (wl >= sl || ril_q[idx]) begin
				ones_a = ril_q[idx] ? BW'(1) : clamp_burst(wl);
				n_ril  = 1'b1;
			end
			if (wi_q != 32'd0 && !prev_q) begin
				n_gil = 1'b0;
				if (!no_run && (d_s1 - 1) <= dl) begin
					if (sp_q[idx]) begin
						if (mw < sl && dsum_s1 < sl) begin
							n_mrg = clamp_merge(dsum_s1 - 1);
						end else begin
							n_ril  = 1'b1;
							ones_b = clamp_burst(dsum_s1);
							n_mrg  = '0;
							n_sp   = 1'b0;
						end
					end else begin
						n_ril  = 1'b1;
						ones_b = clamp_burst(d_s1);
					end
				end
				if (no_run && wide_t'(wi_q) < dl) begin
					zeros = clamp_burst(wide_t'(wi_q));
				end
			end else if (sp_q[idx]) begin
				if (mw + wl >= sl) begin
					ones_b = clamp_burst(mw + wl);
					n_sp   = 1'b0;
					n_mrg  = '0;
					n_ril  = 1'b1;
				end
			end
		end else begin
			if (prev_q) begin
				wl = wide_t'(rl_cur);
				if (wl < sl && (no_run || dwl_s1 > dl || (mw < sl && mw != 0))) begin
					n_sp  = 1'b1;
					n_pwl = rl_cur[3:0];
				end
				n_lre = $signed({1'b0, wi_q}) - 33'sd1;
				n_rl  = '0;
				n_ril = 1'b0;
			end
			d2   = prev_q ? wide_t'(1) : d_s1;
			zsum = prev_q ? (wide_t'(1) + wide_t'(n_pwl) + mw) : dsum_s1;
			if (d2 >= dl) begin
				if (n_sp) begin
					zeros = clamp_burst(zsum);
					n_sp  = 1'b0;
					n_mrg = '0;
					n_gil = 1'b1;
				end else if (gil_q[idx]) begin
					zeros = BW'(1);
				end else begin
					zeros = clamp_burst(d2);
					n_gil = 1'b1;
				end
			end
		end

		// Ones come first in a burst, zeros after; the burst is cut at its limit.
		ones_t  = {1'b0, ones_a} + {1'b0, ones_b};
		ones_e  = (ones_t > {1'b0, BMAX}) ? BMAX : ones_t[BW-1:0];
		room    = BMAX - ones_e;
		zeros_e = (zeros > room) ? room : zeros;
		ones_n  = ones_e;
		rem_n   = ones_e + zeros_e;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ch_q   <= channel;
			cur_q  <= sample_bit;
			prev_q <= previous_bit;
			wi_q   <= sample_index;
		end
		if (cmd.look) begin
			d_s1    <= wide_t'(wi_q) - wide_t'(lre_q[idx]);
			dsum_s1 <= wide_t'(wi_q) - wide_t'(lre_q[idx])
				+ wide_t'(pwl_q[idx]) + wide_t'(mrg_q[idx]);
			dwl_s1  <= wide_t'(wi_q) - wide_t'(lre_q[idx]) - wide_t'(rl_q[idx]) - 1;
		end
		if (cmd.push) begin
			out_ch_q   <= ch_q;
			out_bit_q  <= (ones_q != '0);
			out_last_q <= (rem_q == BW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= 4'd10;
			max_q       <= 6'd40;
			rem_q       <= '0;
			ones_q      <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				lre_q[c] <= -33'sd1;
				rl_q[c]  <= '0;
				pwl_q[c] <= '0;
				sp_q[c]  <= 1'b0;
				ril_q[c] <= 1'b0;
				gil_q[c] <= 1'b0;
				mrg_q[c] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MIN_RUN: min_q <= cfg_data[3:0];
					REG_MAX_GAP: max_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.decide) begin
				lre_q[idx] <= n_lre;
				rl_q[idx]  <= n_rl;
				pwl_q[idx] <= n_pwl;
				sp_q[idx]  <= n_sp;
				ril_q[idx] <= n_ril;
				gil_q[idx] <= n_gil;
				mrg_q[idx] <= n_mrg;
				rem_q      <= rem_n;
				ones_q     <= ones_n;
			end else if (cmd.push) begin
				rem_q <= rem_q - BW'(1);
				if (ones_q != '0) begin
					ones_q <= ones_q - BW'(1);
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_channel   = out_ch_q;
	assign filtered_bit  = out_bit_q;
	assign last_of_burst = out_last_q;

	// The ones still to send never exceed the bits still to send.
	a_ones_le_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= rem_q) else $error("ones count exceeds remaining burst");

	// A burst never grows past its limit.
	a_rem_max: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= BMAX) else $error("burst counter beyond limit");

	// Sending the final bit empties the burst.
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && rem_q == BW'(1) |=> rem_q == '0)
		else $error("burst not empty after its last bit");

	// Bits are only pushed while the output register can take them.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free && rem_q != '0)
		else $error("push without room or without bits");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the binary pulse gap filter core.
`timescale 1ns / 100ps

module tb_top;
	import bpgf_pkg::*;

	localparam int NCHAN     = 3;
	localparam int BURST_CAP = 64;
	localparam int IDLE_LIMIT = 2000;

	// One filtered bit as the block should deliver it.
	typedef struct {
		logic [1:0] chan;
		logic       fbit;
		logic       last;
	} burst_bit_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [5:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  channel;
	logic        sample_bit;
	logic        previous_bit;
	logic [31:0] sample_index;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  out_channel;
	logic        filtered_bit;
	logic        last_of_burst;

	binary_pulse_gap_filter_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.channel      (channel),
		.sample_bit   (sample_bit),
		.previous_bit (previous_bit),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_channel  (out_channel),
		.filtered_bit (filtered_bit),
		.last_of_burst(last_of_burst)
	);

	// Predicted configuration and per-channel filter state.
	longint     min_run;
	longint     max_gap;
	longint     run_end_q[NCHAN];
	int         run_len_q[NCHAN];
	int         short_len_q[NCHAN];
	bit         short_wait_q[NCHAN];
	bit         run_long_q[NCHAN];
	bit         gap_long_q[NCHAN];
	int         merged_q[NCHAN];

	burst_bit_t pending_bits[$];
	burst_bit_t burst_buf[$];

	int  errors;
	int  items_sent;
	int  bits_checked;
	int  idle_cycles;
	bit  quiet;

	// Random-sequence bookkeeping: last bit, next index and run left per channel.
	bit          seq_bit[NCHAN];
	logic [31:0] seq_idx[NCHAN];
	int          seq_left[NCHAN];
	bit          seq_hist[NCHAN];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Appends up to count copies of a bit to the burst under construction; the
	// burst is cut at the cap.
	function automatic void add_bits(input logic [1:0] ch, input bit b, input longint count);
		burst_bit_t e;
		e.chan = ch;
		e.fbit = b;
		e.last = 1'b0;
		for (longint k = 0; k < count && burst_buf.size() < BURST_CAP; k++)
			burst_buf.push_back(e);
	endfunction

	function automatic int clamp_merged(input longint v);
		if (v < 0)
			return 0;
		if (v > MERGE_MAX)
			return MERGE_MAX;
		return int'(v);
	endfunction

	function automatic bit seq_prev(input int c);
		return seq_hist[c];
	endfunction

	// Updates the predicted state for one accepted sample and queues the bits it
	// releases.
	function automatic void filter_sample(input logic [1:0] ch, input bit cur, input bit prev,
			input logic [31:0] idx);
		longint wi;
		longint wl;
		longint pre;
		longint merged;
		longint pwl;
		int c;
		wi = longint'({32'd0, idx});
		burst_buf.delete();
		if (ch >= NCHAN)
			return;
		c = ch;
		if (cur) begin
			if (run_len_q[c] < 65535)
				run_len_q[c]++;
			wl = run_len_q[c];
			if (wl >= min_run || run_long_q[c]) begin
				if (run_long_q[c]) begin
					add_bits(ch, 1, 1);
				end else begin
					add_bits(ch, 1, wl);
					run_long_q[c] = 1;
				end
			end
			pre = run_end_q[c];
			merged = merged_q[c];
			pwl = short_len_q[c];
			if (wi >= 1 && !prev) begin
				gap_long_q[c] = 0;
				if (pre != -1 && wi - pre - 1 <= max_gap) begin
					if (short_wait_q[c]) begin
						if (merged < min_run && merged + wi - pre + pwl < min_run) begin
							merged_q[c] = clamp_merged(merged + pwl + wi - pre - 1);
						end else begin
							run_long_q[c] = 1;
							add_bits(ch, 1, wi - pre + pwl + merged);
							merged_q[c] = 0;
							short_wait_q[c] = 0;
						end
					end else begin
						run_long_q[c] = 1;
						add_bits(ch, 1, wi - pre);
					end
				end
				if (pre == -1 && wi < max_gap)
					add_bits(ch, 0, wi);
			end else if (short_wait_q[c]) begin
				if (merged + wl >= min_run) begin
					add_bits(ch, 1, merged + wl);
					short_wait_q[c] = 0;
					merged_q[c] = 0;
					run_long_q[c] = 1;
				end
			end
		end else begin
			if (prev) begin
				wl = run_len_q[c];
				merged = merged_q[c];
				pre = run_end_q[c];
				if (wl < min_run && (pre == -1 || wi - wl - pre - 1 > max_gap ||
						(merged < min_run && merged != 0))) begin
					short_wait_q[c] = 1;
					short_len_q[c] = int'(wl) & 15;
				end
				run_end_q[c] = wi - 1;
				run_len_q[c] = 0;
				run_long_q[c] = 0;
			end
			pre = run_end_q[c];
			merged = merged_q[c];
			pwl = short_len_q[c];
			if (wi - pre >= max_gap) begin
				if (short_wait_q[c]) begin
					add_bits(ch, 0, wi - pre + pwl + merged);
					short_wait_q[c] = 0;
					merged_q[c] = 0;
					gap_long_q[c] = 1;
				end else if (gap_long_q[c]) begin
					add_bits(ch, 0, 1);
				end else begin
					add_bits(ch, 0, wi - pre);
					gap_long_q[c] = 1;
				end
			end
		end
		if (burst_buf.size() > 0)
			burst_buf[burst_buf.size() - 1].last = 1'b1;
		foreach (burst_buf[i])
			pending_bits.push_back(burst_buf[i]);
	endfunction

	// Sends one item after a random gap and predicts its bits once it is taken.
	// Valid stays high afterwards so back-to-back items need no extra edge.
	task automatic send_sample(input logic [1:0] ch, input bit cur, input bit prev,
			input logic [31:0] idx);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		channel      <= ch;
		sample_bit   <= cur;
		previous_bit <= prev;
		sample_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		filter_sample(ch, cur, prev, idx);
		items_sent++;
	endtask

	// Drops valid and waits until every predicted bit has been seen, then waits on
	// so that an item that released nothing has finished too.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] value);
		drain_block();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_MIN_RUN)
			min_run = value & 6'hF;
		else
			max_gap = value;
	endtask

	// Random but well-formed stream for one channel: alternating runs of ones
	// and zeros with consecutive indices.
	task automatic send_stream_step(input int c);
		bit b;
		if (seq_left[c] == 0) begin
			seq_bit[c]  = !seq_bit[c];
			seq_left[c] = seq_bit[c] ? $urandom_range(1, 13) : $urandom_range(1, 45);
		end
		b = seq_bit[c];
		seq_left[c]--;
		send_sample(c[1:0], b, seq_prev(c), seq_idx[c]);
		seq_idx[c]++;
		seq_hist[c] = b;
	endtask

	// Output side: a random stall per bit, sampled and checked at each edge.
	int stall_left;
	always @(posedge clk) begin
		burst_bit_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bits.size() == 0) begin
				$error("unexpected bit: out_channel %0d filtered_bit %0d last_of_burst %0d",
					out_channel, filtered_bit, last_of_burst);
				errors++;
			end else begin
				e = pending_bits.pop_front();
				if (out_channel !== e.chan) begin
					$error("out_channel: expected %0d, got %0d", e.chan, out_channel);
					errors++;
				end
				if (filtered_bit !== e.fbit) begin
					$error("filtered_bit: expected %0d, got %0d", e.fbit, filtered_bit);
					errors++;
				end
				if (last_of_burst !== e.last) begin
					$error("last_of_burst: expected %0d, got %0d", e.last, last_of_burst);
					errors++;
				end
			end
			bits_checked++;
			stall_left = quiet ? 0 : $urandom_range(0, 15);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: counts cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Default settings: a long run, a short run swallowed, a gap filled, and the
	// leading zeros of a channel with no run yet.
	task automatic test_defaults();
		for (int i = 0; i < 12; i++)
			send_sample(2'd0, 1, i > 0, 32'd5 + i);
		send_sample(2'd0, 0, 1, 32'd17);
		send_sample(2'd0, 1, 0, 32'd20);
		send_sample(2'd0, 0, 1, 32'd21);
		send_sample(2'd0, 0, 0, 32'd70);
	endtask

	// Channel three does not exist, so the block must drop its items silently.
	task automatic test_bad_channel();
		send_sample(2'd3, 1, 0, 32'd9);
		send_sample(2'd3, 0, 1, 32'hFFFF_FFFF);
	endtask

	// Extreme settings, very large and backward indices, a burst cut at the cap
	// and index zero right after ones.
	task automatic test_extremes();
		write_reg(REG_MIN_RUN, 6'd1);
		write_reg(REG_MAX_GAP, 6'd1);
		send_sample(2'd1, 1, 0, 32'd0);
		send_sample(2'd1, 0, 1, 32'd0);
		send_sample(2'd1, 1, 0, 32'd3);
		send_sample(2'd1, 0, 1, 32'hFFFF_FFFF);
		send_sample(2'd1, 1, 0, 32'd2);
		write_reg(REG_MIN_RUN, 6'd10);
		write_reg(REG_MAX_GAP, 6'd40);
		send_sample(2'd2, 1, 0, 32'd100);
		send_sample(2'd2, 0, 1, 32'd101);
		send_sample(2'd2, 0, 0, 32'd5000);
		send_sample(2'd2, 1, 0, 32'd4990);
		send_sample(2'd2, 0, 1, 32'd10);
		write_reg(REG_MIN_RUN, 6'd15);
		write_reg(REG_MAX_GAP, 6'd63);
		send_sample(2'd0, 1, 0, 32'd200);
		send_sample(2'd0, 0, 1, 32'h8000_0000);
	endtask

	// Mostly well-formed streams with random settings, some noise items, a full
	// drain before each setting and one mid-phase, and one stretch with no idling.
	task automatic test_random();
		int c;
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_MIN_RUN, 6'($urandom_range(1, 10)));
			write_reg(REG_MAX_GAP, 6'($urandom_range(1, 40)));
			quiet = (phase == 2);
			for (int i = 0; i < 32; i++) begin
				if ($urandom_range(0, 99) < 15) begin
					send_sample(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), $urandom());
				end else begin
					c = $urandom_range(0, NCHAN - 1);
					send_stream_step(c);
				end
				if (phase == 1 && i == 20)
					drain_block();
			end
			quiet = 0;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_MIN_RUN;
		cfg_data     = '0;
		in_valid     = 1'b0;
		channel      = '0;
		sample_bit   = 1'b0;
		previous_bit = 1'b0;
		sample_index = '0;
		items_sent   = 0;
		quiet        = 0;
		min_run      = 10;
		max_gap      = 40;
		for (int c = 0; c < NCHAN; c++) begin
			run_end_q[c]    = -1;
			run_len_q[c]    = 0;
			short_len_q[c]  = 0;
			short_wait_q[c] = 0;
			run_long_q[c]   = 0;
			gap_long_q[c]   = 0;
			merged_q[c]     = 0;
			seq_bit[c]      = 1;
			seq_hist[c]     = 0;
			seq_idx[c]      = 32'd300 + 32'd1000 * c;
			seq_left[c]     = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_bad_channel();
		test_extremes();
		test_random();

		// Let the last burst drain, then let the block settle.
		drain_block();
		$display("covered %0d items and %0d filtered bits over several settings,",
			items_sent, bits_checked);
		$display("including missing channels, capped bursts and backward indices.");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: files.f
design/bpgf_pkg.sv
design/bpgf_ctrl.sv
design/bpgf_datapath.sv
design/binary_pulse_gap_filter_core.sv
verif/tb_top.sv
